/* design/cwd_pkg.sv */
package cwd_pkg;

  localparam int SAMPLE_W   = 13;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 12;
  localparam int OUT_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE       = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_RMS_LIMIT     = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_RMS_LIMIT_TWO = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_NEIGHBOR_FRAC     = 4'd3;

  localparam logic [6:0]  WINDOW_SIZE_RST       = 7'd20;
  localparam logic [11:0] LOW_RMS_LIMIT_RST     = 12'd14;
  localparam logic [11:0] LOW_RMS_LIMIT_TWO_RST = 12'd16;
  localparam logic [9:0]  NEIGHBOR_FRAC_RST     = 10'd200;

  localparam int QUEUE_DEPTH     = 4;
  localparam int SNAP_TICKS      = 100;
  localparam int FRAC_SCALE      = 1000;
  localparam int DEAD_SCALE      = 990;
  localparam int TIGHT_LIMIT     = 2000;
  localparam int MIN_LOW_WINDOWS = 4;

  typedef struct packed {
    logic [6:0]  window_size;
    logic [11:0] low_rms_limit;
    logic [11:0] low_rms_limit_two;
    logic [9:0]  neighbor_frac_limit;
  } cwd_cfg_t;

endpackage

/* design/cwd_fifo.sv */
module cwd_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);

  localparam int DEPTH = cwd_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign valid = (cnt_r != '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + AW'(1);
      end
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

/* design/cwd_front.sv */
module cwd_front #(
  parameter int MAX_TICKS  = 16384,
  parameter int MAX_WINDOW = 64,
  localparam int TW   = $clog2(MAX_TICKS + 1),
  localparam int PW   = $clog2(MAX_WINDOW + 1),
  localparam int SW   = 14 + $clog2(MAX_WINDOW),
  localparam int QW   = 25 + $clog2(MAX_WINDOW),
  localparam int RECW = 2 + TW + QW + SW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic signed [cwd_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                in_last,
  input  logic [PW-1:0]                       w_eff,
  output logic                                q_push,
  output logic [RECW-1:0]                     q_wdata,
  input  logic                                q_full
);

  logic signed [SW-1:0] sum_r, sum_nxt, sum_a;
  logic [QW-1:0]        sq_r, sq_nxt, sq_a;
  logic [PW-1:0]        pos_r, pos_nxt, pos_a;
  logic [TW-1:0]        tick_r, tick_nxt, n_a;
  logic signed [25:0]   vv;
  logic                 accept, counting, close_w;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign counting  = (tick_r < TW'(MAX_TICKS));
  assign vv        = in_sample * in_sample;
  assign sum_a     = sum_r + SW'(in_sample);
  assign sq_a      = sq_r + QW'($unsigned(vv));
  assign pos_a     = pos_r + PW'(1);
  assign n_a       = counting ? tick_r + TW'(1) : tick_r;
  assign close_w   = counting && (pos_a >= w_eff);
  assign q_push    = accept && (close_w || in_last);
  assign q_wdata   = {in_last, close_w, n_a, sq_a, sum_a};

  always_comb begin
    sum_nxt  = sum_r;
    sq_nxt   = sq_r;
    pos_nxt  = pos_r;
    tick_nxt = tick_r;
    if (accept) begin
      if (in_last) begin
        sum_nxt  = '0;
        sq_nxt   = '0;
        pos_nxt  = '0;
        tick_nxt = '0;
      end else if (counting) begin
        tick_nxt = n_a;
        if (close_w) begin
          sum_nxt = '0;
          sq_nxt  = '0;
          pos_nxt = '0;
        end else begin
          sum_nxt = sum_a;
          sq_nxt  = sq_a;
          pos_nxt = pos_a;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      sq_r   <= '0;
      pos_r  <= '0;
      tick_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      sq_r   <= sq_nxt;
      pos_r  <= pos_nxt;
      tick_r <= tick_nxt;
    end
  end

endmodule

/* design/cwd_back.sv */
module cwd_back #(
  parameter int MAX_TICKS  = 16384,
  parameter int MAX_WINDOW = 64,
  localparam int TW   = $clog2(MAX_TICKS + 1),
  localparam int PW   = $clog2(MAX_WINDOW + 1),
  localparam int SW   = 14 + $clog2(MAX_WINDOW),
  localparam int QW   = 25 + $clog2(MAX_WINDOW),
  localparam int RECW = 2 + TW + QW + SW
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cwd_pkg::cwd_cfg_t                 cfg,
  input  logic [PW-1:0]                     w_eff,
  input  logic                              q_valid,
  input  logic [RECW-1:0]                   q_rdata,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cwd_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int PQ  = PW + QW;
  localparam int SS  = 2 * SW;
  localparam int DW  = ((PQ > SS) ? PQ : SS) + 1;
  localparam int AW  = PW + 12;
  localparam int LW  = 2 * AW;
  localparam int CW  = ((DW + 7) > LW) ? (DW + 7) : LW;
  localparam int NW  = $clog2(MAX_TICKS / 2 + 1);
  localparam int RW  = TW + 1;
  localparam int EW  = TW + PW + 2;
  localparam int FW  = RW + PW + 2;
  localparam int PN  = NW + 10;
  localparam int PL  = NW + PW;
  localparam int P9  = TW + 10;
  localparam int PK  = NW + PW + 10;
  localparam int PC  = (PK > P9) ? PK : P9;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_CMP  = 2'd2;
  localparam logic [1:0] F_OUT  = 2'd3;

  localparam logic signed [FW-1:0] SNAP = FW'(cwd_pkg::SNAP_TICKS);

  logic signed [SW-1:0] r_sum;
  logic [SW-1:0]        r_abs;
  logic [QW-1:0]        r_sq;
  logic [TW-1:0]        r_n;
  logic                 r_win, r_last;

  assign r_sum  = q_rdata[SW-1:0];
  assign r_sq   = q_rdata[SW+QW-1:SW];
  assign r_n    = q_rdata[SW+QW+TW-1:SW+QW];
  assign r_win  = q_rdata[RECW-2];
  assign r_last = q_rdata[RECW-1];
  assign r_abs  = r_sum[SW-1] ? $unsigned(-r_sum) : $unsigned(r_sum);

  logic [AW-1:0] a_r, b_r;
  logic [LW-1:0] lim1_r, lim2_r;

  always_ff @(posedge clk) begin
    a_r    <= AW'(w_eff) * AW'(cfg.low_rms_limit);
    b_r    <= AW'(w_eff) * AW'(cfg.low_rms_limit_two);
    lim1_r <= LW'(a_r) * LW'(a_r);
    lim2_r <= LW'(b_r) * LW'(b_r);
  end

  logic          s1_v_r, s1_win_r, s1_last_r;
  logic [TW-1:0] s1_n_r;
  logic [PQ-1:0] wq_r;
  logic [SS-1:0] ss_r;
  logic          s2_v_r, s2_win_r, s2_last_r;
  logic [TW-1:0] s2_n_r;
  logic [2:0]    s2_mark_r;
  logic [1:0]    fin_st_r;
  logic          adv, retire;

  logic [DW-1:0]   d;
  logic [DW-2:0]   dz;
  logic [CW-1:0]   d256, l1, l2;
  logic [2:0]      mark;

  assign d    = DW'(wq_r) - DW'(ss_r);
  assign dz   = d[DW-1] ? '0 : d[DW-2:0];
  assign d256 = CW'({dz, 8'b0});
  assign l1   = CW'(lim1_r);
  assign l2   = CW'(lim2_r);
  assign mark = {d256 > l1, d256 < l2, d256 < l1};

  assign adv    = !(s2_v_r && s2_last_r && (fin_st_r != F_IDLE));
  assign q_pop  = adv && q_valid;
  assign retire = adv && s2_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_win_r  <= r_win;
      s1_last_r <= r_last;
      s1_n_r    <= r_n;
      wq_r      <= PQ'(w_eff) * PQ'(r_sq);
      ss_r      <= SS'(r_abs) * SS'(r_abs);
      s2_win_r  <= s1_win_r;
      s2_last_r <= s1_last_r;
      s2_n_r    <= s1_n_r;
      s2_mark_r <= mark;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= q_valid;
      s2_v_r <= s1_v_r;
    end
  end

  logic [NW-1:0]        low_r, low_nxt, nb_r, nb_nxt;
  logic                 open_r, open_nxt;
  logic signed [RW-1:0] rf_r, rf_nxt, rl_r, rl_nxt;
  logic [2:0]           mk0_r, mk0_nxt, mk1_r, mk1_nxt;
  logic [EW-1:0]        i_e, w_e;
  logic                 pair;

  assign i_e  = EW'(s2_n_r) - EW'(1);
  assign w_e  = EW'(w_eff);
  assign pair = (mk1_r[0] && s2_mark_r[1]) || (mk1_r[1] && s2_mark_r[0]);

  always_comb begin
    low_nxt  = low_r;
    nb_nxt   = nb_r;
    open_nxt = open_r;
    rf_nxt   = rf_r;
    rl_nxt   = rl_r;
    mk0_nxt  = mk0_r;
    mk1_nxt  = mk1_r;
    if (s2_win_r) begin
      if (s2_mark_r[0]) begin
        low_nxt = low_r + NW'(1);
      end
      if (i_e >= EW'(3) * w_e) begin
        if (mk1_r[0] && (mk0_r[2] || s2_mark_r[2])) begin
          nb_nxt = nb_r + NW'(1);
        end
        if (pair) begin
          if (!open_r) begin
            open_nxt = 1'b1;
            rf_nxt   = RW'(i_e - EW'(2) * w_e + EW'(1));
          end
          rl_nxt = RW'(i_e - w_e + EW'(1));
        end
      end
      mk0_nxt = mk1_r;
      mk1_nxt = s2_mark_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= '0;
      nb_r   <= '0;
      open_r <= 1'b0;
      rf_r   <= '1;
      rl_r   <= '1;
      mk0_r  <= '0;
      mk1_r  <= '0;
    end else if (retire) begin
      if (s2_last_r) begin
        low_r  <= '0;
        nb_r   <= '0;
        open_r <= 1'b0;
        rf_r   <= '1;
        rl_r   <= '1;
        mk0_r  <= '0;
        mk1_r  <= '0;
      end else begin
        low_r  <= low_nxt;
        nb_r   <= nb_nxt;
        open_r <= open_nxt;
        rf_r   <= rf_nxt;
        rl_r   <= rl_nxt;
        mk0_r  <= mk0_nxt;
        mk1_r  <= mk1_nxt;
      end
    end
  end

  logic [TW-1:0]        fn_r, sf_r, ef_r;
  logic [NW-1:0]        fl_r, fnn_r;
  logic signed [RW-1:0] frf_r, frl_r;
  logic [PN-1:0]        p_nn_r, p_fl_r;
  logic [PL-1:0]        p_lw_r;
  logic [P9-1:0]        p_n990_r;
  logic [PK-1:0]        p_lw1000_r;
  logic signed [FW-1:0] s_r, e_r, diff_r, n_s, w_s;
  logic                 frac_ok_r, tight_r, many_r;
  logic                 out_valid_r, found, dead, out_load;
  logic [cwd_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [14:0]          start_v, stop_v;

  assign n_s = $signed(FW'(fn_r));
  assign w_s = $signed(FW'(w_eff));

  always_ff @(posedge clk) begin
    if (retire && s2_last_r) begin
      fn_r  <= s2_n_r;
      fl_r  <= low_nxt;
      fnn_r <= nb_nxt;
      frf_r <= rf_nxt;
      frl_r <= rl_nxt;
    end
    if (fin_st_r == F_MUL) begin
      p_nn_r   <= PN'(fnn_r) * PN'(cwd_pkg::FRAC_SCALE);
      p_fl_r   <= PN'(fl_r) * PN'(cfg.neighbor_frac_limit);
      p_lw_r   <= PL'(fl_r) * PL'(w_eff);
      p_n990_r <= P9'(fn_r) * P9'(cwd_pkg::DEAD_SCALE);
      s_r      <= FW'(frf_r) - w_s;
      e_r      <= FW'(frl_r) + w_s + w_s;
      diff_r   <= FW'(frl_r) - FW'(frf_r);
    end
    if (fin_st_r == F_CMP) begin
      frac_ok_r  <= (p_nn_r < p_fl_r);
      tight_r    <= (p_fl_r < PN'(cwd_pkg::TIGHT_LIMIT)) && (diff_r == $signed(FW'(p_lw_r)));
      p_lw1000_r <= PK'(p_lw_r) * PK'(cwd_pkg::FRAC_SCALE);
      sf_r       <= (s_r < SNAP) ? '0 : TW'(s_r);
      ef_r       <= ((n_s - e_r) < SNAP) ? fn_r : TW'(e_r);
      many_r     <= (fl_r > NW'(cwd_pkg::MIN_LOW_WINDOWS));
    end
  end

  assign found    = (frac_ok_r || tight_r) && many_r;
  assign dead     = found && (PC'(p_lw1000_r) > PC'(p_n990_r));
  assign start_v  = (found && !dead) ? 15'(sf_r) : 15'd0;
  assign stop_v   = !found ? 15'd0 : (dead ? 15'(fn_r) : 15'(ef_r));
  assign out_load = (fin_st_r == F_OUT) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_st_r <= F_IDLE;
    end else begin
      unique case (fin_st_r)
        F_IDLE: begin
          if (retire && s2_last_r) begin
            fin_st_r <= F_MUL;
          end
        end
        F_MUL: fin_st_r <= F_CMP;
        F_CMP: fin_st_r <= F_OUT;
        F_OUT: begin
          if (out_load) begin
            fin_st_r <= F_IDLE;
          end
        end
        default: fin_st_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'b0, 15'(fn_r), 14'(fl_r), stop_v, start_v, dead, found};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/chirp_window_detector.sv */
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | tdata[12:0] sample, tlast marks final sample
// out_    | out | out_tvalid/tready  | one item per waveform, fields in tdata
// cfg_    | in  | cfg_valid/ready    | cfg_index register, cfg_data value
//
// One sample per cycle while the record queue has room; the back pipeline takes
// one window record per cycle through a multiply stage and a compare stage, then
// a state update. A waveform's result then passes the finish sequencer's multiply,
// compare and output states; the sequencer holds the pipeline at a following final
// record until the output register takes the result. Synchronous active-low reset
// clears all waveform state and loads register defaults; no clearing pass.
module chirp_window_detector #(
  parameter int MAX_TICKS  = 16384,
  parameter int MAX_WINDOW = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // [12:0] sample, [15:13] zero
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] chirp_found, [1] dead_channel, [16:2] span_begin, [31:17] span_end,
  // [45:32] low_window_count, [60:46] tick_count, [63:61] zero
  output logic [cwd_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [cwd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [cwd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int TW   = $clog2(MAX_TICKS + 1);
  localparam int PW   = $clog2(MAX_WINDOW + 1);
  localparam int SW   = 14 + $clog2(MAX_WINDOW);
  localparam int QW   = 25 + $clog2(MAX_WINDOW);
  localparam int RECW = 2 + TW + QW + SW;

  cwd_pkg::cwd_cfg_t cfg_r;
  logic [PW-1:0]     w_eff;
  logic              q_push, q_full, q_pop, q_valid;
  logic [RECW-1:0]   q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_size         <= cwd_pkg::WINDOW_SIZE_RST;
      cfg_r.low_rms_limit       <= cwd_pkg::LOW_RMS_LIMIT_RST;
      cfg_r.low_rms_limit_two   <= cwd_pkg::LOW_RMS_LIMIT_TWO_RST;
      cfg_r.neighbor_frac_limit <= cwd_pkg::NEIGHBOR_FRAC_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cwd_pkg::REG_WINDOW_SIZE:       cfg_r.window_size         <= cfg_data[6:0];
        cwd_pkg::REG_LOW_RMS_LIMIT:     cfg_r.low_rms_limit       <= cfg_data[11:0];
        cwd_pkg::REG_LOW_RMS_LIMIT_TWO: cfg_r.low_rms_limit_two   <= cfg_data[11:0];
        cwd_pkg::REG_NEIGHBOR_FRAC:     cfg_r.neighbor_frac_limit <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cfg_r.window_size < 7'd2) begin
      w_eff = PW'(2);
    end else if (int'(cfg_r.window_size) > MAX_WINDOW) begin
      w_eff = PW'(MAX_WINDOW);
    end else begin
      w_eff = PW'(cfg_r.window_size);
    end
  end

  cwd_front #(
    .MAX_TICKS (MAX_TICKS),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_sample($signed(in_tdata[12:0])),
    .in_last  (in_tlast),
    .w_eff    (w_eff),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  cwd_fifo #(
    .WIDTH(RECW)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .valid(q_valid)
  );

  cwd_back #(
    .MAX_TICKS (MAX_TICKS),
    .MAX_WINDOW(MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .w_eff     (w_eff),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("record pushed into full queue");

  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[31:1] == 31'd0))
    else $error("flags or span set on non-chirping result");

  a_dead_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |->
      (out_tdata[0] && (out_tdata[16:2] == 15'd0) && (out_tdata[31:17] == out_tdata[60:46])))
    else $error("dead channel result does not cover whole waveform");

endmodule
